>>> rtl/core/tplm_pkg.sv
// ----------------------------------------------------------------------------
// tplm_pkg
// Shared widths, register map and result type of the tape pulse length meter.
// ----------------------------------------------------------------------------
package tplm_pkg;

    localparam int SAMPLE_BITS        = 8;
    localparam int TRIGGER_BITS       = 7;
    localparam int LENGTH_BITS        = 24;
    localparam int COUNT_BITS_DEFAULT = 24;
    localparam int ADDR_BITS          = 3;
    localparam int DATA_BITS          = 32;

    localparam logic [TRIGGER_BITS-1:0] TRIGGER_RESET = 7'h06;
    localparam logic [LENGTH_BITS-1:0]  LENGTH_MAX    = '1;

    // register index, taken from paddr[2]
    localparam logic REG_TRIGGER_LEVEL  = 1'b0;
    localparam logic REG_HALF_WAVE_MODE = 1'b1;

    typedef struct packed {
        logic                   emit;
        logic                   is_lead_in;
        logic [LENGTH_BITS-1:0] length_samples;
    } result_t;

endpackage

>>> rtl/core/tape_pulse_length_meter.sv
// ----------------------------------------------------------------------------
// tape_pulse_length_meter
// Measures tape pulse lengths in samples from a signed 8-bit sample stream.
// ----------------------------------------------------------------------------
// Takes one signed 8-bit tape sample per transfer on s_* and returns pulse
// lengths on m_*. The first result is the lead-in length (m_is_lead_in = 1):
// the index of the first sample at or below zero after one at or above
// trigger_level. After that a result goes out each time a valid run ends.
// Full-wave mode measures positive swings against the minimum seen since
// the last result; half-wave mode measures each signed half wave against
// zero at trigger_level / 2. Lengths saturate at 2^COUNT_BITS - 1 and at the
// 24-bit output maximum. Rate: one sample per clock unless an emitting sample
// must wait. A sample sits in the input register, tplm_core makes the state
// update and result decision combinationally, and the result register takes
// the result when the sample advances. A sample that ends no run moves on
// even while a result waits; only a sample that emits holds in the input
// register until the result register is drained, and s_ready stays low
// behind it. Registers (APB, write only while idle):
//   0x0 trigger_level  [6:0], reset 6
//   0x4 half_wave_mode [0],   reset 0
// ----------------------------------------------------------------------------
module tape_pulse_length_meter #(
    parameter int COUNT_BITS = tplm_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // sample input
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [tplm_pkg::SAMPLE_BITS-1:0] s_sample,
    // length output
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [tplm_pkg::LENGTH_BITS-1:0]        m_length_samples,
    output logic                                    m_is_lead_in,
    // configuration
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [tplm_pkg::ADDR_BITS-1:0]          paddr,
    input  logic [tplm_pkg::DATA_BITS-1:0]          pwdata,
    output logic [tplm_pkg::DATA_BITS-1:0]          prdata,
    output logic                                    pready
);
    import tplm_pkg::*;

    // configuration registers
    logic [TRIGGER_BITS-1:0] trigger_level_reg;
    logic                    half_wave_mode_reg;
    logic                    cfg_write;

    // input stage
    logic                          in_valid_reg, in_valid_next;
    logic signed [SAMPLE_BITS-1:0] in_sample_reg;

    // result stage
    logic                   out_valid_reg, out_valid_next;
    logic [LENGTH_BITS-1:0] out_length_reg;
    logic                   out_lead_reg;

    logic    advance;
    result_t result;

    // ---- APB ----
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        case (paddr[2])
            REG_TRIGGER_LEVEL:  prdata = DATA_BITS'(trigger_level_reg);
            REG_HALF_WAVE_MODE: prdata = DATA_BITS'(half_wave_mode_reg);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trigger_level_reg  <= TRIGGER_RESET;
            half_wave_mode_reg <= 1'b0;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_TRIGGER_LEVEL:  trigger_level_reg  <= pwdata[TRIGGER_BITS-1:0];
                REG_HALF_WAVE_MODE: half_wave_mode_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    // ---- handshake ----
    // the buffered sample moves on when it emits nothing, when the result
    // slot is free, or when the slot drains now
    assign advance = in_valid_reg && (!result.emit || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance && result.emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            // samples that end no run leave the slot as it drains
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_sample_reg <= s_sample;
        end
        if (advance && result.emit) begin
            out_length_reg <= result.length_samples;
            out_lead_reg   <= result.is_lead_in;
        end
    end

    // ---- measurement ----
    tplm_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (advance),
        .sample         (in_sample_reg),
        .trigger_level  (trigger_level_reg),
        .half_wave_mode (half_wave_mode_reg),
        .result         (result)
    );

    assign m_valid          = out_valid_reg;
    assign m_length_samples = out_length_reg;
    assign m_is_lead_in     = out_lead_reg;

endmodule

>>> rtl/core/tplm_core.sv
// ----------------------------------------------------------------------------
// tplm_core
// Measurement state and per-sample update: lead-in, full-wave, half-wave.
// ----------------------------------------------------------------------------
module tplm_core #(
    parameter int COUNT_BITS = tplm_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   advance,
    input  logic signed [tplm_pkg::SAMPLE_BITS-1:0] sample,
    input  logic [tplm_pkg::TRIGGER_BITS-1:0]      trigger_level,
    input  logic                                   half_wave_mode,
    output tplm_pkg::result_t                      result
);
    import tplm_pkg::*;

    typedef enum logic [1:0] {
        PH_WAIT_TRIG,
        PH_WAIT_LOW,
        PH_MEASURE,
        PH_IN_RUN
    } phase_t;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    phase_t                        phase_reg, phase_next;
    logic [COUNT_BITS-1:0]         count_reg, count_next;
    logic signed [SAMPLE_BITS-1:0] run_min_reg, run_min_next;
    logic                          run_neg_reg, run_neg_next;
    logic                          run_valid_reg, run_valid_next;
    logic                          lead_pend_reg, lead_pend_next;

    logic [COUNT_BITS-1:0]  count_bumped;
    logic [31:0]            count_wide;
    logic [LENGTH_BITS-1:0] length_sat;
    logic                   s_neg;
    logic                   s_zero;
    logic                   s_le_zero;
    logic [SAMPLE_BITS-1:0] s_mag;
    logic                   hits_lead_trig;
    logic                   hits_full_trig;
    logic                   hits_half_trig;

    assign count_bumped = (count_reg == COUNT_MAX) ? count_reg : count_reg + COUNT_ONE;
    assign count_wide   = 32'(count_reg);
    assign length_sat   = (count_wide > 32'(LENGTH_MAX)) ? LENGTH_MAX
                                                         : count_wide[LENGTH_BITS-1:0];

    assign s_neg     = sample[SAMPLE_BITS-1];
    assign s_zero    = (sample == '0);
    assign s_le_zero = s_neg || s_zero;
    assign s_mag     = s_neg ? (SAMPLE_BITS'(0) - sample) : sample;

    assign hits_lead_trig = $signed({sample[SAMPLE_BITS-1], sample})
                            >= $signed({2'b00, trigger_level});
    assign hits_full_trig = ($signed({{2{sample[SAMPLE_BITS-1]}}, sample})
                             - $signed({{2{run_min_reg[SAMPLE_BITS-1]}}, run_min_reg}))
                            >= $signed({3'b000, trigger_level});
    assign hits_half_trig = s_mag >= {2'b00, trigger_level[TRIGGER_BITS-1:1]};

    always_comb begin
        phase_next     = phase_reg;
        count_next     = count_bumped;
        run_min_next   = run_min_reg;
        run_neg_next   = run_neg_reg;
        run_valid_next = run_valid_reg;
        lead_pend_next = lead_pend_reg;
        result.emit           = 1'b0;
        result.is_lead_in     = 1'b0;
        result.length_samples = length_sat;

        case (phase_reg)
            PH_WAIT_TRIG, PH_WAIT_LOW: begin
                if (phase_reg == PH_WAIT_TRIG && hits_lead_trig) begin
                    phase_next = PH_WAIT_LOW;
                end
                if ((phase_reg == PH_WAIT_LOW || hits_lead_trig) && s_le_zero) begin
                    // lead-in ends; this sample opens the first pulse
                    result.emit       = 1'b1;
                    result.is_lead_in = 1'b1;
                    count_next        = COUNT_ONE;
                    run_valid_next    = 1'b0;
                    phase_next        = PH_MEASURE;
                    run_min_next      = '0;
                    lead_pend_next    = 1'b1;
                    if (half_wave_mode) begin
                        if (!s_zero) begin
                            run_neg_next   = 1'b1;
                            lead_pend_next = 1'b0;
                        end
                    end else if (s_neg) begin
                        run_min_next = sample;
                    end
                end
            end
            default: begin
                if (!half_wave_mode) begin
                    if (s_le_zero) begin
                        if (run_valid_reg) begin
                            result.emit    = 1'b1;
                            count_next     = COUNT_ONE;
                            run_valid_next = 1'b0;
                            lead_pend_next = 1'b1;
                            phase_next     = PH_MEASURE;
                            run_min_next   = s_neg ? sample : '0;
                        end else if (sample < run_min_reg) begin
                            run_min_next = sample;
                        end
                    end else if (hits_full_trig) begin
                        run_valid_next = 1'b1;
                    end
                end else if (lead_pend_reg) begin
                    if (!s_zero) begin
                        run_neg_next   = s_neg;
                        lead_pend_next = 1'b0;
                        run_valid_next = 1'b0;
                        phase_next     = PH_MEASURE;
                    end
                end else if (s_zero) begin
                    if (phase_reg == PH_IN_RUN) begin
                        if (run_valid_reg) begin
                            result.emit  = 1'b1;
                            count_next   = COUNT_ONE;
                            run_min_next = '0;
                        end
                        run_valid_next = 1'b0;
                        lead_pend_next = 1'b1;
                        phase_next     = PH_MEASURE;
                    end
                end else if (s_neg == run_neg_reg) begin
                    phase_next = PH_IN_RUN;
                    if (hits_half_trig) begin
                        run_valid_next = 1'b1;
                    end
                end else begin
                    // sign flip: run ends, this sample is the next untested one
                    if (run_valid_reg) begin
                        result.emit  = 1'b1;
                        count_next   = COUNT_ONE;
                        run_min_next = '0;
                    end
                    run_valid_next = 1'b0;
                    lead_pend_next = 1'b0;
                    run_neg_next   = s_neg;
                    phase_next     = PH_MEASURE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_WAIT_TRIG;
            count_reg     <= '0;
            run_min_reg   <= '0;
            run_neg_reg   <= 1'b0;
            run_valid_reg <= 1'b0;
            lead_pend_reg <= 1'b1;
        end else if (advance) begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            run_min_reg   <= run_min_next;
            run_neg_reg   <= run_neg_next;
            run_valid_reg <= run_valid_next;
            lead_pend_reg <= lead_pend_next;
        end
    end

endmodule
